>>> rtl/core/mwsm_pkg.sv
// ----------------------------------------------------------------------------
// Mecanum wheel speed mixer package
// Shared widths, reset values, register indexes and wheel slots.
// ----------------------------------------------------------------------------
package mwsm_pkg;

  // Field widths of the command, the result and the registers.
  localparam int IN_W       = 16;
  localparam int OUT_W      = 16;
  localparam int GEOM_W     = 16;
  localparam int LIMIT_W    = 15;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  // Turn rate times geometry sum: signed by unsigned product.
  localparam int WR_W = IN_W + GEOM_W + 1;

  // Register reset values.
  localparam logic [GEOM_W-1:0]  GEOM_RESET  = 16'd512;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd100;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GEOMETRY_SUM = 1'b0,
    CFG_WHEEL_LIMIT  = 1'b1
  } cfg_reg_t;

  // Wheel slots inside the datapath arrays.
  localparam int NUM_WHEELS       = 4;
  localparam int SLOT_FRONT_LEFT  = 0;
  localparam int SLOT_FRONT_RIGHT = 1;
  localparam int SLOT_REAR_LEFT   = 2;
  localparam int SLOT_REAR_RIGHT  = 3;

endpackage

>>> rtl/core/mwsm_divider.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Unsigned division, one quotient bit per register stage. The quotient must
// be known to fit in QUO_W bits (dividend < divisor << QUO_W).
// ----------------------------------------------------------------------------
module mwsm_divider #(
  parameter int DVD_W = 49,
  parameter int DIV_W = 34,
  parameter int QUO_W = 15
) (
  input  logic             clk,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic [QUO_W-1:0] quotient
);

  // Working width holds the dividend and the divisor at its largest shift.
  localparam int W = (DVD_W > DIV_W + QUO_W) ? DVD_W : DIV_W + QUO_W;

  logic [W-1:0]     rem_r [QUO_W];
  logic [DIV_W-1:0] den_r [QUO_W];
  logic [QUO_W-1:0] quo_r [QUO_W];

  // Each stage tries the divisor at one shift, most significant bit first.
  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    logic [W-1:0]     rem_in;
    logic [W-1:0]     trial;
    logic [DIV_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;

    if (s == 0) begin : g_first
      assign rem_in = W'(dividend);
      assign den_in = divisor;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign quo_in = quo_r[s-1];
    end

    assign trial = W'(den_in) << (QUO_W - 1 - s);

    always_ff @(posedge clk) begin
      den_r[s] <= den_in;
      if (rem_in >= trial) begin
        rem_r[s] <= rem_in - trial;
        quo_r[s] <= quo_in | (QUO_W'(1) << (QUO_W - 1 - s));
      end else begin
        rem_r[s] <= rem_in;
        quo_r[s] <= quo_in;
      end
    end
  end

  assign quotient = quo_r[QUO_W-1];

endmodule

>>> rtl/core/mecanum_wheel_speed_mixer.sv
// ----------------------------------------------------------------------------
// Mecanum wheel speed mixer
// Pipeline from start to out_valid: six datapath stages, one stage per bit
// of the 15-bit quotient divider, and one output stage.
// Throughput: one transaction per clock; busy is high only during reset.
// Reset clears every valid bit and loads geometry_sum = 512, wheel_limit = 100.
// Results are shown for exactly one cycle; the receiver cannot stall them.
// ----------------------------------------------------------------------------
module mecanum_wheel_speed_mixer #(
  parameter int FRACTION_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [mwsm_pkg::IN_W-1:0]     in_forward_speed,
  input  logic signed [mwsm_pkg::IN_W-1:0]     in_sideways_speed,
  input  logic signed [mwsm_pkg::IN_W-1:0]     in_turn_rate,
  output logic                                 out_valid,
  output logic signed [mwsm_pkg::OUT_W-1:0]    out_front_left,
  output logic signed [mwsm_pkg::OUT_W-1:0]    out_front_right,
  output logic signed [mwsm_pkg::OUT_W-1:0]    out_rear_left,
  output logic signed [mwsm_pkg::OUT_W-1:0]    out_rear_right,
  input  logic                                 cfg_we,
  input  logic [mwsm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mwsm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int NW      = mwsm_pkg::NUM_WHEELS;
  localparam int LIM_W   = mwsm_pkg::LIMIT_W;
  localparam int VEL_W   = mwsm_pkg::IN_W + FRACTION_BITS;
  localparam int SUM_W   = VEL_W + 1;
  localparam int WR_W    = mwsm_pkg::WR_W;
  localparam int BASE_W  = (SUM_W > WR_W) ? SUM_W : WR_W;
  localparam int WHEEL_W = BASE_W + 2;
  localparam int MAG_W   = WHEEL_W - 1;
  localparam int THR_W   = LIM_W + 2 * FRACTION_BITS;
  localparam int CMP_W   = (MAG_W > THR_W) ? MAG_W : THR_W;
  localparam int DVD_W   = MAG_W + LIM_W;
  localparam int DIV_LAT = LIM_W;
  localparam int LATENCY = 7 + DIV_LAT;

  typedef struct packed {
    logic [NW-1:0]            neg;
    logic                     scale;
    logic [NW-1:0][LIM_W-1:0] unscaled;
  } side_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [mwsm_pkg::GEOM_W-1:0] geometry_sum_r;
  logic [LIM_W-1:0]            wheel_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geometry_sum_r <= mwsm_pkg::GEOM_RESET;
      wheel_limit_r  <= mwsm_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (mwsm_pkg::cfg_reg_t'(cfg_index))
        mwsm_pkg::CFG_GEOMETRY_SUM: geometry_sum_r <= cfg_wdata[mwsm_pkg::GEOM_W-1:0];
        mwsm_pkg::CFG_WHEEL_LIMIT:  wheel_limit_r  <= cfg_wdata[LIM_W-1:0];
      endcase
    end
  end

  // The pipeline takes a new command in every cycle outside reset.
  assign busy = !rst_n;

  // --------------------------------------------------------------------------
  // Stage 1: scale velocities to the product format, form sum and difference,
  // and multiply turn rate by the geometry sum.
  // --------------------------------------------------------------------------
  logic                    p1_valid_r;
  logic signed [SUM_W-1:0] p1_sum_r;
  logic signed [SUM_W-1:0] p1_dif_r;
  logic signed [WR_W-1:0]  p1_wr_r;
  logic signed [VEL_W-1:0] vx;
  logic signed [VEL_W-1:0] vy;
  logic signed [WR_W-1:0]  wr_nxt;

  always_comb begin
    vx     = VEL_W'(in_forward_speed) <<< FRACTION_BITS;
    vy     = VEL_W'(in_sideways_speed) <<< FRACTION_BITS;
    wr_nxt = WR_W'(in_turn_rate) * WR_W'($signed({1'b0, geometry_sum_r}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else begin
      p1_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    p1_sum_r <= SUM_W'(vx) + SUM_W'(vy);
    p1_dif_r <= SUM_W'(vx) - SUM_W'(vy);
    p1_wr_r  <= wr_nxt;
  end

  // --------------------------------------------------------------------------
  // Stage 2: the four wheel speeds with the mecanum sign pattern.
  // --------------------------------------------------------------------------
  logic                      p2_valid_r;
  logic signed [WHEEL_W-1:0] p2_wheel_r [NW];
  logic signed [WHEEL_W-1:0] sum_x;
  logic signed [WHEEL_W-1:0] dif_x;
  logic signed [WHEEL_W-1:0] wr_x;

  always_comb begin
    sum_x = WHEEL_W'(p1_sum_r);
    dif_x = WHEEL_W'(p1_dif_r);
    wr_x  = WHEEL_W'(p1_wr_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_valid_r <= 1'b0;
    end else begin
      p2_valid_r <= p1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    p2_wheel_r[mwsm_pkg::SLOT_FRONT_LEFT]  <= sum_x - wr_x;
    p2_wheel_r[mwsm_pkg::SLOT_FRONT_RIGHT] <= wr_x - dif_x;
    p2_wheel_r[mwsm_pkg::SLOT_REAR_LEFT]   <= -(dif_x + wr_x);
    p2_wheel_r[mwsm_pkg::SLOT_REAR_RIGHT]  <= sum_x + wr_x;
  end

  // --------------------------------------------------------------------------
  // Stage 3: split each wheel into sign and magnitude.
  // --------------------------------------------------------------------------
  logic             p3_valid_r;
  logic [MAG_W-1:0] p3_mag_r [NW];
  logic [NW-1:0]    p3_neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_valid_r <= 1'b0;
    end else begin
      p3_valid_r <= p2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NW; i++) begin
      p3_neg_r[i] <= p2_wheel_r[i][WHEEL_W-1];
      p3_mag_r[i] <= MAG_W'(p2_wheel_r[i][WHEEL_W-1] ? -p2_wheel_r[i] : p2_wheel_r[i]);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: first level of the maximum tree.
  // --------------------------------------------------------------------------
  logic             p4_valid_r;
  logic [MAG_W-1:0] p4_mag_r [NW];
  logic [NW-1:0]    p4_neg_r;
  logic [MAG_W-1:0] p4_pmax_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p4_valid_r <= 1'b0;
    end else begin
      p4_valid_r <= p3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    p4_mag_r     <= p3_mag_r;
    p4_neg_r     <= p3_neg_r;
    p4_pmax_r[0] <= (p3_mag_r[1] > p3_mag_r[0]) ? p3_mag_r[1] : p3_mag_r[0];
    p4_pmax_r[1] <= (p3_mag_r[3] > p3_mag_r[2]) ? p3_mag_r[3] : p3_mag_r[2];
  end

  // --------------------------------------------------------------------------
  // Stage 5: largest wheel magnitude.
  // --------------------------------------------------------------------------
  logic             p5_valid_r;
  logic [MAG_W-1:0] p5_mag_r [NW];
  logic [NW-1:0]    p5_neg_r;
  logic [MAG_W-1:0] p5_maxabs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p5_valid_r <= 1'b0;
    end else begin
      p5_valid_r <= p4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    p5_mag_r    <= p4_mag_r;
    p5_neg_r    <= p4_neg_r;
    p5_maxabs_r <= (p4_pmax_r[1] > p4_pmax_r[0]) ? p4_pmax_r[1] : p4_pmax_r[0];
  end

  // --------------------------------------------------------------------------
  // Stage 6: compare against the limit, form the dividends, and the
  // unscaled integer part of each wheel.
  // --------------------------------------------------------------------------
  logic             p6_valid_r;
  logic [DVD_W-1:0] p6_dvd_r [NW];
  logic [MAG_W-1:0] p6_maxabs_r;
  side_t            p6_side_r;
  logic [CMP_W-1:0] threshold;

  assign threshold = CMP_W'(wheel_limit_r) << (2 * FRACTION_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p6_valid_r <= 1'b0;
    end else begin
      p6_valid_r <= p5_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    p6_maxabs_r     <= p5_maxabs_r;
    p6_side_r.neg   <= p5_neg_r;
    p6_side_r.scale <= CMP_W'(p5_maxabs_r) > threshold;
    for (int i = 0; i < NW; i++) begin
      p6_dvd_r[i]              <= DVD_W'(p5_mag_r[i]) * DVD_W'(wheel_limit_r);
      p6_side_r.unscaled[i]    <= LIM_W'(p5_mag_r[i] >> (2 * FRACTION_BITS));
    end
  end

  // --------------------------------------------------------------------------
  // Divider lanes: magnitude * limit / maxabs, truncated.
  // --------------------------------------------------------------------------
  logic [LIM_W-1:0] div_q [NW];

  for (genvar i = 0; i < NW; i++) begin : g_div
    mwsm_divider #(
      .DVD_W (DVD_W),
      .DIV_W (MAG_W),
      .QUO_W (LIM_W)
    ) u_div (
      .clk      (clk),
      .dividend (p6_dvd_r[i]),
      .divisor  (p6_maxabs_r),
      .quotient (div_q[i])
    );
  end

  // Side information travels alongside the divider stages.
  logic [DIV_LAT-1:0] dly_valid_r;
  side_t              dly_side_r [DIV_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dly_valid_r <= '0;
    end else begin
      dly_valid_r <= {dly_valid_r[DIV_LAT-2:0], p6_valid_r};
    end
  end

  always_ff @(posedge clk) begin
    dly_side_r[0] <= p6_side_r;
    for (int k = 1; k < DIV_LAT; k++) begin
      dly_side_r[k] <= dly_side_r[k-1];
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: pick scaled or unscaled magnitude and restore the sign.
  // --------------------------------------------------------------------------
  logic                               out_valid_r;
  logic signed [mwsm_pkg::OUT_W-1:0]  out_wheel_r [NW];
  side_t                              side_last;
  logic [LIM_W-1:0]                   res_mag [NW];

  assign side_last = dly_side_r[DIV_LAT-1];

  always_comb begin
    for (int i = 0; i < NW; i++) begin
      res_mag[i] = side_last.scale ? div_q[i] : side_last.unscaled[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dly_valid_r[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NW; i++) begin
      out_wheel_r[i] <= side_last.neg[i] ? -mwsm_pkg::OUT_W'(res_mag[i])
                                         :  mwsm_pkg::OUT_W'(res_mag[i]);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_front_left  = out_wheel_r[mwsm_pkg::SLOT_FRONT_LEFT];
  assign out_front_right = out_wheel_r[mwsm_pkg::SLOT_FRONT_RIGHT];
  assign out_rear_left   = out_wheel_r[mwsm_pkg::SLOT_REAR_LEFT];
  assign out_rear_right  = out_wheel_r[mwsm_pkg::SLOT_REAR_RIGHT];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  logic [mwsm_pkg::OUT_W-1:0] fl_abs;

  assign fl_abs = out_front_left[mwsm_pkg::OUT_W-1] ? -out_front_left : out_front_left;

  // Every accepted transaction raises the result strobe once it has passed the whole pipeline.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("result strobe does not match accepted command timing");

  // Scaling only happens with a nonzero largest magnitude.
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (p6_valid_r && p6_side_r.scale) |-> (p6_maxabs_r != '0))
    else $error("scaling selected with a zero divisor");

  // The delivered front left wheel speed never exceeds the configured limit.
  a_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (fl_abs <= mwsm_pkg::OUT_W'(wheel_limit_r)))
    else $error("front left wheel speed exceeds the wheel limit");

endmodule

>>> tb/mecanum_wheel_speed_mixer_tb.sv
// ----------------------------------------------------------------------------
// Mecanum wheel speed mixer testbench
// Sends body velocity commands through the start/busy port and predicts the
// four wheel speeds with an independent fixed-point mixer. It also applies
// the proportional limit and truncates toward zero. Every result is checked
// field by field against the oldest prediction. The run covers directed
// corner cases first, then random commands under several register settings
// and several sender idle rates.
// ----------------------------------------------------------------------------
module mecanum_wheel_speed_mixer_tb;

  localparam int FRAC_BITS   = 8;
  localparam int PIPE_DELAY  = 22;
  localparam int CYCLE_LIMIT = 200000;

  // One set of predicted wheel speeds.
  typedef struct {
    logic signed [mwsm_pkg::OUT_W-1:0] front_left;
    logic signed [mwsm_pkg::OUT_W-1:0] front_right;
    logic signed [mwsm_pkg::OUT_W-1:0] rear_left;
    logic signed [mwsm_pkg::OUT_W-1:0] rear_right;
  } wheel_set_t;

  logic                                clk;
  logic                                rst_n;
  logic                                start;
  logic                                busy;
  logic signed [mwsm_pkg::IN_W-1:0]    in_forward_speed;
  logic signed [mwsm_pkg::IN_W-1:0]    in_sideways_speed;
  logic signed [mwsm_pkg::IN_W-1:0]    in_turn_rate;
  logic                                out_valid;
  logic signed [mwsm_pkg::OUT_W-1:0]   out_front_left;
  logic signed [mwsm_pkg::OUT_W-1:0]   out_front_right;
  logic signed [mwsm_pkg::OUT_W-1:0]   out_rear_left;
  logic signed [mwsm_pkg::OUT_W-1:0]   out_rear_right;
  logic                                cfg_we;
  mwsm_pkg::cfg_reg_t                  cfg_index;
  logic [mwsm_pkg::CFG_DATA_W-1:0]     cfg_wdata;

  // Local copy of the register file used by the wheel predictor.
  logic [mwsm_pkg::GEOM_W-1:0]         geom_model;
  logic [mwsm_pkg::LIMIT_W-1:0]        limit_model;

  wheel_set_t               expected_wheels[$];
  int                       fail_count;
  int                       mismatch_count;
  int                       cycle_count;
  int                       sender_idle_pct;

  mecanum_wheel_speed_mixer #(
    .FRACTION_BITS(FRAC_BITS)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_forward_speed (in_forward_speed),
    .in_sideways_speed(in_sideways_speed),
    .in_turn_rate     (in_turn_rate),
    .out_valid        (out_valid),
    .out_front_left   (out_front_left),
    .out_front_right  (out_front_right),
    .out_rear_left    (out_rear_left),
    .out_rear_right   (out_rear_right),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // Free-running clock, 20 time units per period.
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("mecanum_wheel_speed_mixer_tb NOT OK");
      $finish;
    end
  end

  // Mix one command into four wheels, limit proportionally, truncate to integers.
  function automatic wheel_set_t mix_wheels(logic signed [mwsm_pkg::IN_W-1:0] fwd,
                                            logic signed [mwsm_pkg::IN_W-1:0] side,
                                            logic signed [mwsm_pkg::IN_W-1:0] turn);
    longint     vx;
    longint     vy;
    longint     wr;
    longint     lim;
    longint     peak;
    longint     mag;
    longint     wheel[mwsm_pkg::NUM_WHEELS];
    longint     speed[mwsm_pkg::NUM_WHEELS];
    wheel_set_t res;
    vx  = longint'(fwd) * (longint'(1) << FRAC_BITS);
    vy  = longint'(side) * (longint'(1) << FRAC_BITS);
    wr  = longint'(turn) * longint'(geom_model);
    lim = longint'(limit_model);
    wheel[mwsm_pkg::SLOT_FRONT_LEFT]  = vx + vy - wr;
    wheel[mwsm_pkg::SLOT_FRONT_RIGHT] = -vx + vy + wr;
    wheel[mwsm_pkg::SLOT_REAR_LEFT]   = -vx + vy - wr;
    wheel[mwsm_pkg::SLOT_REAR_RIGHT]  = vx + vy + wr;
    peak = 0;
    for (int i = 0; i < mwsm_pkg::NUM_WHEELS; i++) begin
      mag = (wheel[i] < 0) ? -wheel[i] : wheel[i];
      if (mag > peak) peak = mag;
    end
    // Scale only when the peak is strictly above the limit; both paths
    // truncate toward zero.
    for (int i = 0; i < mwsm_pkg::NUM_WHEELS; i++) begin
      if (peak > (lim << (2 * FRAC_BITS))) speed[i] = (wheel[i] * lim) / peak;
      else speed[i] = wheel[i] / (longint'(1) << (2 * FRAC_BITS));
    end
    res.front_left  = speed[mwsm_pkg::SLOT_FRONT_LEFT][mwsm_pkg::OUT_W-1:0];
    res.front_right = speed[mwsm_pkg::SLOT_FRONT_RIGHT][mwsm_pkg::OUT_W-1:0];
    res.rear_left   = speed[mwsm_pkg::SLOT_REAR_LEFT][mwsm_pkg::OUT_W-1:0];
    res.rear_right  = speed[mwsm_pkg::SLOT_REAR_RIGHT][mwsm_pkg::OUT_W-1:0];
    return res;
  endfunction

  // Random speed: full range, corner values, magnitudes up to the limit, or small magnitudes.
  function automatic logic signed [mwsm_pkg::IN_W-1:0] rand_speed();
    int mode;
    int span;
    int value;
    mode = $urandom_range(0, 3);
    span = int'(limit_model) << FRAC_BITS;
    if (span > 32767) span = 32767;
    case (mode)
      0: begin
        value = $urandom_range(0, 65535) - 32768;
      end
      1: begin
        case ($urandom_range(0, 3))
          0: value = -32768;
          1: value = 32767;
          2: value = 0;
          default: value = -1;
        endcase
      end
      2: begin
        value = $urandom_range(0, span);
        if ($urandom_range(0, 1) == 1) value = -value;
      end
      default: begin
        value = $urandom_range(0, 4096);
        if ($urandom_range(0, 1) == 1) value = -value;
      end
    endcase
    return value[mwsm_pkg::IN_W-1:0];
  endfunction

  // Send one command; the transaction completes at the first edge with busy low.
  task automatic send_command(logic signed [mwsm_pkg::IN_W-1:0] fwd,
                              logic signed [mwsm_pkg::IN_W-1:0] side,
                              logic signed [mwsm_pkg::IN_W-1:0] turn);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start             <= 1'b0;
      in_forward_speed  <= mwsm_pkg::IN_W'($urandom);
      in_sideways_speed <= mwsm_pkg::IN_W'($urandom);
      in_turn_rate      <= mwsm_pkg::IN_W'($urandom);
      @(posedge clk);
    end
    start             <= 1'b1;
    in_forward_speed  <= fwd;
    in_sideways_speed <= side;
    in_turn_rate      <= turn;
    do @(posedge clk); while (busy !== 1'b0);
    expected_wheels.push_back(mix_wheels(fwd, side, turn));
  endtask

  // Hold the sender off until every predicted result has been seen.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (expected_wheels.size() != 0);
  endtask

  // Write both registers back to back; the block must be idle.
  task automatic set_config(logic [mwsm_pkg::CFG_DATA_W-1:0] geom,
                            logic [mwsm_pkg::CFG_DATA_W-1:0] limit_word);
    cfg_we    <= 1'b1;
    cfg_index <= mwsm_pkg::CFG_GEOMETRY_SUM;
    cfg_wdata <= geom;
    @(posedge clk);
    geom_model <= geom[mwsm_pkg::GEOM_W-1:0];
    cfg_index  <= mwsm_pkg::CFG_WHEEL_LIMIT;
    cfg_wdata  <= limit_word;
    @(posedge clk);
    limit_model <= limit_word[mwsm_pkg::LIMIT_W-1:0];
    cfg_we      <= 1'b0;
  endtask

  // Check every result against the oldest prediction.
  always @(posedge clk) begin : check_results
    wheel_set_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (expected_wheels.size() == 0) begin
        fail_count = fail_count + 1;
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= 10)
          $display("unexpected result: FL %0d FR %0d RL %0d RR %0d", out_front_left,
                   out_front_right, out_rear_left, out_rear_right);
      end else begin
        want = expected_wheels.pop_front();
        if (out_front_left !== want.front_left || out_front_right !== want.front_right ||
            out_rear_left !== want.rear_left || out_rear_right !== want.rear_right) begin
          fail_count = fail_count + 1;
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10)
            $display("wheel mismatch: expected FL %0d FR %0d RL %0d RR %0d, got %0d %0d %0d %0d",
                     want.front_left, want.front_right, want.rear_left, want.rear_right,
                     out_front_left, out_front_right, out_rear_left, out_rear_right);
        end
      end
    end
  end

  // Reset register values: limit boundary, pure axes and full-scale commands.
  task automatic test_reset_config();
    send_command(16'sd0, 16'sd0, 16'sd0);
    send_command(16'sd25600, 16'sd0, 16'sd0);
    send_command(16'sd25601, 16'sd0, 16'sd0);
    send_command(-16'sd25599, 16'sd0, 16'sd0);
    send_command(16'sd0, 16'sd32767, 16'sd0);
    send_command(16'sd0, -16'sd32768, 16'sd0);
    send_command(16'sd0, 16'sd0, 16'sd32767);
    send_command(16'sd0, 16'sd0, -16'sd32768);
    send_command(16'sd32767, 16'sd32767, 16'sd32767);
    send_command(-16'sd32768, -16'sd32768, -16'sd32768);
    send_command(16'sd1, -16'sd1, 16'sd1);
    wait_drained();
  endtask

  // Geometry sum at zero (turn rate has no effect) and at full scale.
  task automatic test_geometry_extremes();
    set_config(16'd0, 16'd32767);
    send_command(16'sd100, 16'sd0, -16'sd32768);
    send_command(-16'sd32768, -16'sd32768, 16'sd32767);
    send_command(16'sd0, 16'sd0, 16'sd32767);
    wait_drained();
    set_config(16'd65535, 16'd32767);
    send_command(16'sd0, 16'sd0, -16'sd32768);
    send_command(16'sd32767, -16'sd32768, 16'sd32767);
    wait_drained();
  endtask

  // Smallest nonzero limit, zero limit, and a limit write with the unused top bit set.
  task automatic test_limit_extremes();
    set_config(16'd512, 16'd1);
    send_command(16'sd300, 16'sd0, 16'sd0);
    send_command(16'sd256, 16'sd0, 16'sd0);
    send_command(16'sd1, 16'sd0, 16'sd0);
    wait_drained();
    set_config(16'd512, 16'd0);
    send_command(16'sd5000, -16'sd3, 16'sd7);
    send_command(16'sd0, 16'sd0, 16'sd0);
    wait_drained();
    set_config(16'd512, 16'h8032);
    send_command(16'sd25600, 16'sd0, 16'sd0);
    wait_drained();
  endtask

  // Random commands under one register setting and one sender idle rate.
  task automatic test_random_phase(int count, int idle_pct,
                                   logic [mwsm_pkg::CFG_DATA_W-1:0] geom,
                                   logic [mwsm_pkg::CFG_DATA_W-1:0] limit_word);
    wait_drained();
    set_config(geom, limit_word);
    sender_idle_pct = idle_pct;
    for (int i = 0; i < count; i++) send_command(rand_speed(), rand_speed(), rand_speed());
    wait_drained();
    sender_idle_pct = 0;
  endtask

  initial begin
    fail_count        = 0;
    mismatch_count    = 0;
    sender_idle_pct   = 0;
    geom_model        = mwsm_pkg::GEOM_RESET;
    limit_model       = mwsm_pkg::LIMIT_RESET;
    rst_n             <= 1'b0;
    start             <= 1'b0;
    in_forward_speed  <= '0;
    in_sideways_speed <= '0;
    in_turn_rate      <= '0;
    cfg_we            <= 1'b0;
    cfg_index         <= mwsm_pkg::CFG_GEOMETRY_SUM;
    cfg_wdata         <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_config();
    test_geometry_extremes();
    test_limit_extremes();
    test_random_phase(300, 0, 16'd512, 16'd100);
    test_random_phase(300, 88, 16'd65535, 16'd32767);
    test_random_phase(300, 29, 16'($urandom_range(0, 65535)), 16'd1);
    test_random_phase(250, 0, 16'($urandom_range(0, 65535)),
                      16'($urandom_range(1, 32767)));
    test_random_phase(200, 88, 16'd0, 16'($urandom_range(1, 32767)));
    test_random_phase(200, 29, 16'($urandom_range(0, 65535)),
                      16'($urandom_range(1, 300)));

    // Let the pipeline settle so that stray results would still be caught.
    repeat (PIPE_DELAY + 8) @(posedge clk);
    if (expected_wheels.size() != 0) fail_count = fail_count + 1;
    if (fail_count == 0) begin
      $display("mecanum_wheel_speed_mixer_tb OK");
    end else begin
      $display("mecanum_wheel_speed_mixer_tb NOT OK");
    end
    $finish;
  end

endmodule
